FILE: rtl/atl_pkg.sv
// Shared types and constants of the arithmetic token lexer.
`timescale 1ns / 1ps

package atl_pkg;

  localparam int VALUE_BITS = 31;
  localparam int LINE_BITS  = 16;

  // Width of value * 10 + digit before the saturation check.
  localparam int WIDE       = VALUE_BITS + 4;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam int OBDEPTH    = 4;
  localparam int OBPTR_BITS = $clog2(OBDEPTH);
  localparam int OBCNT_BITS = $clog2(OBDEPTH + 1);

  localparam logic [7:0] CH_TERM    = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    KIND_NUMBER = 3'd0,
    KIND_PLUS   = 3'd1,
    KIND_MINUS  = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_PLUS,
    CLS_MINUS,
    CLS_SKIP,
    CLS_NEWLINE,
    CLS_TERM,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_BITS-1:0]  value;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } res_t;

endpackage

FILE: rtl/atl_front.sv
// Front end: input handshake and character classification.
`timescale 1ns / 1ps

module atl_front
  import atl_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [3:0] diff;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign diff     = in_char_code[3:0] - CH_ZERO[3:0];

  always_comb begin
    cmd.digit = diff;
    if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) begin
      cmd.cls = CLS_DIGIT;
    end else if (in_char_code == CH_TERM) begin
      cmd.cls = CLS_TERM;
    end else if (in_char_code == CH_PLUS) begin
      cmd.cls = CLS_PLUS;
    end else if (in_char_code == CH_MINUS) begin
      cmd.cls = CLS_MINUS;
    end else if (in_char_code == CH_SPACE || in_char_code == CH_TAB) begin
      cmd.cls = CLS_SKIP;
    end else if (in_char_code == CH_NEWLINE) begin
      cmd.cls = CLS_NEWLINE;
    end else begin
      cmd.cls = CLS_OTHER;
    end
  end

endmodule

FILE: rtl/atl_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module atl_queue
  import atl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t head_cmd
);

  cmd_t                 ent_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt;
  logic [QPTR_BITS-1:0] rd_r, rd_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign full     = (cnt_r == QCNT_BITS'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign head_cmd = ent_r[rd_r];
  assign do_pop   = pop && q_valid;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_BITS'(push) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/atl_back.sv
// Back end: lexer state, token generation and output buffer.
`timescale 1ns / 1ps

module atl_back
  import atl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  head_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_token_kind,
  output logic [VALUE_BITS-1:0] out_number_value,
  output logic [LINE_BITS-1:0]  out_line_number,
  output logic                  out_last_of_run
);

  logic                  in_number_r, in_number_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic                  halted_r, halted_nxt;

  res_t                  ob_r [OBDEPTH];
  logic [OBPTR_BITS-1:0] ob_wr_r, ob_rd_r;
  logic [OBCNT_BITS-1:0] ob_cnt_r;
  logic                  out_pop;

  logic [WIDE-1:0]       acc_wide;
  logic [1:0]            n_res;
  res_t                  res0, res1;
  kind_t                 own_kind;
  logic                  own_emit;
  res_t                  head_res;

  // Accept a command only while two result slots are guaranteed free.
  assign pop     = q_valid && (ob_cnt_r <= OBCNT_BITS'(OBDEPTH - 2));
  assign out_pop = out_valid && out_ready;

  assign acc_wide = (WIDE'(acc_r) << 3) + (WIDE'(acc_r) << 1) + WIDE'(head_cmd.digit);

  always_comb begin
    in_number_nxt = in_number_r;
    acc_nxt       = acc_r;
    line_nxt      = line_r;
    halted_nxt    = halted_r;
    n_res         = 2'd0;
    own_emit      = 1'b0;
    own_kind      = KIND_END;
    res0          = '{kind: KIND_NUMBER, value: acc_r, line: line_r, last: 1'b1};
    res1          = '{kind: KIND_END, value: '0, line: line_r, last: 1'b1};

    if (pop) begin
      if (halted_r) begin
        if (head_cmd.cls == CLS_TERM) begin
          in_number_nxt = 1'b0;
          acc_nxt       = '0;
          line_nxt      = LINE_BITS'(1);
          halted_nxt    = 1'b0;
        end
      end else if (head_cmd.cls == CLS_DIGIT) begin
        in_number_nxt = 1'b1;
        if (!in_number_r) begin
          acc_nxt = VALUE_BITS'(head_cmd.digit);
        end else if (acc_wide > WIDE'({VALUE_BITS{1'b1}})) begin
          acc_nxt = '1;
        end else begin
          acc_nxt = acc_wide[VALUE_BITS-1:0];
        end
      end else begin
        in_number_nxt = 1'b0;
        acc_nxt       = '0;
        unique case (head_cmd.cls)
          CLS_TERM: begin
            own_emit = 1'b1;
            own_kind = KIND_END;
            line_nxt = LINE_BITS'(1);
          end
          CLS_PLUS: begin
            own_emit = 1'b1;
            own_kind = KIND_PLUS;
          end
          CLS_MINUS: begin
            own_emit = 1'b1;
            own_kind = KIND_MINUS;
          end
          CLS_NEWLINE: begin
            if (line_r != '1) begin
              line_nxt = line_r + 1'b1;
            end
          end
          CLS_OTHER: begin
            own_emit   = 1'b1;
            own_kind   = KIND_ERROR;
            halted_nxt = 1'b1;
          end
          default: begin
          end
        endcase

        if (in_number_r) begin
          res0.last = !own_emit;
          res1.kind = own_kind;
          n_res     = own_emit ? 2'd2 : 2'd1;
        end else begin
          res0.kind  = own_kind;
          res0.value = '0;
          n_res      = own_emit ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r <= 1'b0;
      acc_r       <= '0;
      line_r      <= LINE_BITS'(1);
      halted_r    <= 1'b0;
      ob_wr_r     <= '0;
      ob_rd_r     <= '0;
      ob_cnt_r    <= '0;
    end else begin
      in_number_r <= in_number_nxt;
      acc_r       <= acc_nxt;
      line_r      <= line_nxt;
      halted_r    <= halted_nxt;
      ob_wr_r     <= ob_wr_r + OBPTR_BITS'(n_res);
      ob_rd_r     <= out_pop ? ob_rd_r + 1'b1 : ob_rd_r;
      ob_cnt_r    <= ob_cnt_r + OBCNT_BITS'(n_res) - OBCNT_BITS'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      ob_r[ob_wr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      ob_r[ob_wr_r + 1'b1] <= res1;
    end
  end

  assign head_res         = ob_r[ob_rd_r];
  assign out_valid        = (ob_cnt_r != '0);
  assign out_token_kind   = head_res.kind;
  assign out_number_value = head_res.value;
  assign out_line_number  = head_res.line;
  assign out_last_of_run  = head_res.last;

endmodule

FILE: rtl/arith_token_lexer.sv
// Top level of the arithmetic token lexer.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------
// in_      | input     | in_valid/in_ready   | in_char_code[7:0]
// out_     | output    | out_valid/out_ready | out_token_kind[2:0], out_number_value[30:0],
//          |           |                     | out_line_number[15:0], out_last_of_run
//
// One character item is taken per cycle while the four-entry command queue has room.
// The back end retires one queued character per cycle; the rate is set by that single
// state update (accumulate by ten, or emit up to two tokens into the output buffer).
// A character is retired only while two slots of the four-entry output buffer are free.
// A result is registered in the command queue and then in the output buffer before it is
// valid, and it stays in the output buffer until the consumer takes it.
// Synchronous active-low reset clears queues and returns the lexer state to line one.

module arith_token_lexer
  import atl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_token_kind,
  output logic [VALUE_BITS-1:0] out_number_value,
  output logic [LINE_BITS-1:0]  out_line_number,
  output logic                  out_last_of_run
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t head_cmd;

  // Classify each accepted character and push it into the queue.
  atl_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Decouple input from token generation so either side may stall.
  atl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head_cmd (head_cmd)
  );

  // Advance the lexer state and hold results until the consumer takes them.
  atl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .head_cmd         (head_cmd),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_line_number  (out_line_number),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

FILE: tb/tb_arith_token_lexer.sv
// Self-checking testbench for the arithmetic token lexer.
`timescale 1ns / 1ps

import atl_pkg::*;

// Predicts the token stream from accepted characters and checks each result item.
class token_scoreboard;
  localparam logic [VALUE_BITS-1:0] VALUE_TOP = {VALUE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LINE_TOP  = {LINE_BITS{1'b1}};

  res_t                  token_q[$];
  bit                    in_digits;
  logic [VALUE_BITS-1:0] acc;
  logic [LINE_BITS-1:0]  cur_line;
  bit                    halted;
  int                    errors;
  int                    chars_seen;
  int                    tokens_checked;
  int                    kind_seen[5];
  int                    saturated_numbers;

  function new();
    clear_state();
  endfunction

  function void clear_state();
    in_digits = 1'b0;
    acc       = '0;
    cur_line  = LINE_BITS'(1);
    halted    = 1'b0;
  endfunction

  function void push_token(kind_t kind, logic [VALUE_BITS-1:0] value);
    res_t tok;
    tok.kind  = kind;
    tok.value = value;
    tok.line  = cur_line;
    tok.last  = 1'b0;
    token_q.push_back(tok);
    kind_seen[kind]++;
    if (kind == KIND_NUMBER && value == VALUE_TOP) saturated_numbers++;
  endfunction

  // Advance the lexer state by one accepted character.
  function void note_char(logic [7:0] c);
    int          depth_before;
    logic [63:0] wide;
    depth_before = token_q.size();
    chars_seen++;
    if (halted) begin
      if (c == CH_TERM) clear_state();
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!in_digits) begin
        in_digits = 1'b1;
        acc       = VALUE_BITS'(c - CH_ZERO);
      end else begin
        wide = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
        acc  = (wide > 64'(VALUE_TOP)) ? VALUE_TOP : wide[VALUE_BITS-1:0];
      end
      return;
    end
    // a pending number goes out first, on the line held before this character
    if (in_digits) begin
      push_token(KIND_NUMBER, acc);
      in_digits = 1'b0;
      acc       = '0;
    end
    if (c == CH_TERM) begin
      push_token(KIND_END, '0);
      clear_state();
    end else if (c == CH_PLUS) begin
      push_token(KIND_PLUS, '0);
    end else if (c == CH_MINUS) begin
      push_token(KIND_MINUS, '0);
    end else if (c == CH_NEWLINE) begin
      if (cur_line != LINE_TOP) cur_line++;
    end else if (c != CH_SPACE && c != CH_TAB) begin
      push_token(KIND_ERROR, '0);
      halted = 1'b1;
    end
    if (token_q.size() > depth_before) token_q[token_q.size()-1].last = 1'b1;
  endfunction

  task report(string msg);
    if (errors < 40) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_token(logic [2:0] kind, logic [VALUE_BITS-1:0] value,
                   logic [LINE_BITS-1:0] line_no, logic last);
    res_t want;
    if (token_q.size() == 0) begin
      report($sformatf("unexpected token kind=%0d value=%0d line=%0d last=%0b",
                       kind, value, line_no, last));
      return;
    end
    want = token_q.pop_front();
    tokens_checked++;
    if (kind !== want.kind)
      report($sformatf("token %0d kind %0d, want %0d", tokens_checked, kind, want.kind));
    if (value !== want.value)
      report($sformatf("token %0d value %0d, want %0d", tokens_checked, value, want.value));
    if (line_no !== want.line)
      report($sformatf("token %0d line %0d, want %0d", tokens_checked, line_no, want.line));
    if (last !== want.last)
      report($sformatf("token %0d last %0b, want %0b", tokens_checked, last, want.last));
  endtask

  function int outstanding();
    return token_q.size();
  endfunction

  task check_drained();
    if (token_q.size() != 0)
      report($sformatf("%0d expected tokens never arrived", token_q.size()));
  endtask
endclass

module tb_arith_token_lexer;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_char_code;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_token_kind;
  logic [VALUE_BITS-1:0] out_number_value;
  logic [LINE_BITS-1:0]  out_line_number;
  logic                  out_last_of_run;

  token_scoreboard sb;
  int              cycles;
  int              items_sent;
  int              snd_idle_pct;
  int              rcv_idle_pct;
  bit              hold_req;

  arith_token_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_line_number  (out_line_number),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Count cycles; the watchdog below reads this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Watchdog: end the run if it overstays the cycle limit.
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("tb_arith_token_lexer NOT OK");
    $finish;
  end

  // Sample both handshakes at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_char(in_char_code);
    if (rst_n && out_valid && out_ready)
      sb.check_token(out_token_kind, out_number_value, out_line_number, out_last_of_run);
  end

  // Receiver: random back-pressure, plus a long hold-off on request. The hold
  // is counted here so the sender keeps offering items and the block fills up.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offer one character and hold it until the block takes it. Idle cycles
  // are inserted in front at the sender's current rate.
  task send_char(logic [7:0] c);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task send_number(int ndig);
    for (int i = 0; i < ndig; i++) send_char(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // One string: mostly well-formed arithmetic with random content, sometimes
  // raw noise, always closed by the terminator.
  task send_expression();
    int n_tok;
    int pick;
    if ($urandom_range(9) == 0) begin
      n_tok = $urandom_range(1, 8);
      for (int i = 0; i < n_tok; i++) send_char(8'($urandom_range(255)));
      send_char(CH_TERM);
      return;
    end
    n_tok = $urandom_range(1, 10);
    for (int i = 0; i < n_tok; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)
        send_number(($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4));
      else if (pick < 55) send_char(CH_PLUS);
      else if (pick < 70) send_char(CH_MINUS);
      else if (pick < 80) send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
      else if (pick < 90) send_char(CH_NEWLINE);
      else if (pick < 95) send_text("2147483647");
      else send_char(8'($urandom_range(1, 255)));
    end
    send_char(CH_TERM);
  endtask

  task wait_for_drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    sb           = new();
    cycles       = 0;
    items_sent   = 0;
    hold_req     = 1'b0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = 8'h00;
    out_ready    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: light sender gaps, heavy receiver stalls.
    snd_idle_pct = 19;
    rcv_idle_pct = 52;

    // Directed: lone terminator, each operator and blank, saturation with the
    // number flushed by the terminator, a number ahead of a newline, error
    // followed by ignored input, and a zero digit ahead of a high byte.
    send_char(CH_TERM);
    send_char(CH_PLUS);
    send_char(CH_MINUS);
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_NEWLINE);
    send_text("2147483648");
    send_char(CH_TERM);
    send_text("7\n");
    send_char(8'hFF);
    send_char(CH_NINE);
    send_char(CH_TERM);
    send_char(CH_ZERO);
    send_char(8'h80);
    send_char(CH_TERM);

    // Stall the output for a long stretch while the input keeps coming.
    hold_req = 1'b1;
    while (items_sent < 600) send_expression();

    // Phase two: the other way round, with one full pause half way.
    snd_idle_pct = 52;
    rcv_idle_pct = 19;
    while (items_sent < 900) send_expression();
    in_valid <= 1'b0;
    wait_for_drain();
    @(posedge clk);
    while (items_sent < 1200) send_expression();

    // Phase three: no idling on either side.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (items_sent < 1700) send_expression();
    send_text("5+");
    send_char(CH_NEWLINE);
    send_char(CH_TERM);
    send_text("1-");
    send_char(CH_TERM);

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("Sent %0d characters, checked %0d tokens (%0d number, %0d plus, %0d minus,",
             items_sent, sb.tokens_checked, sb.kind_seen[KIND_NUMBER],
             sb.kind_seen[KIND_PLUS], sb.kind_seen[KIND_MINUS]);
    $display("  %0d error, %0d end), %0d saturated numbers, long output stall and a drain pause",
             sb.kind_seen[KIND_ERROR], sb.kind_seen[KIND_END], sb.saturated_numbers);
    if (sb.errors == 0) begin
      $display("tb_arith_token_lexer OK");
    end else begin
      $display("tb_arith_token_lexer NOT OK");
    end
    $finish;
  end

endmodule
